// File: design/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg: shared types for the segment intersection point core
// Coordinate width and the packed transaction payloads of both channels.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int COORD_BITS = 24;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic   found;
    coord_t cross_x;
    coord_t cross_y;
    logic   parallel_flag;
  } crossing_t;

endpackage

// File: design/segment_intersection_point_core.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_core: pipelined integer segment crossing
// Rejects pairs without y overlap, forms exact cross-product ratios, tests
// the endpoint rule and divides out the crossing point with rounding.
// ----------------------------------------------------------------------------
//  channel  | ports                               | payload
//  ---------+-------------------------------------+-------------
//  input    | item_valid, item_stall, item        | seg_pair_t
//  output   | result_valid, result_stall, result  | crossing_t
//
//  One transaction enters per cycle unless a stall at the output has backed it up.
//  The depth is set by the restoring divider, one quotient bit per stage.
//  Every stage has its own valid bit and takes new data when it is empty or
//  its successor moves, so bubbles collapse under a stall at the output.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module segment_intersection_point_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  sip_pkg::seg_pair_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output sip_pkg::crossing_t  result
);

  localparam int CW = sip_pkg::COORD_BITS;
  localparam int DW = CW + 1;        // coordinate differences
  localparam int PW = 2 * DW;        // cross products, |d|, |tn|
  localparam int SW = PW + 1;        // d, sn, tn
  localparam int LW = DW;            // low slice of |tn|
  localparam int HW = PW - LW;       // high slice of |tn|
  localparam int AW = DW;            // |direction|
  localparam int NW = PW + AW;       // numerator
  localparam int QW = DW;            // quotient bits
  localparam int IW = CW + 2;        // rounded sum before trim
  localparam int DS = 7;             // first divider stage
  localparam int NS = QW + 9;        // stage count

  typedef struct packed {
    logic [NW-1:0]          rx;
    logic [NW-1:0]          ry;
    logic [QW-1:0]          qx;
    logic [QW-1:0]          qy;
    logic [PW-1:0]          dmag;
    logic signed [CW-1:0]   ax;
    logic signed [CW-1:0]   ay;
    logic                   sx;
    logic                   sy;
    logic                   found;
    logic                   par;
  } div_stage_t;

  logic [NS-1:0] st_v;
  logic [NS:0]   rdy;

  // stage 1
  logic signed [CW-1:0] s1_ax, s1_ay;
  logic signed [DW-1:0] s1_d1x, s1_d1y, s1_d2x, s1_d2y, s1_ox, s1_oy;
  logic                 s1_rej;
  // stage 2
  logic signed [CW-1:0] s2_ax, s2_ay;
  logic signed [DW-1:0] s2_d1x, s2_d1y;
  logic signed [PW-1:0] s2_pd0, s2_pd1, s2_ps0, s2_ps1, s2_pt0, s2_pt1;
  logic                 s2_rej;
  // stage 3
  logic signed [CW-1:0] s3_ax, s3_ay;
  logic signed [DW-1:0] s3_d1x, s3_d1y;
  logic signed [SW-1:0] s3_d, s3_sn, s3_tn;
  logic                 s3_rej;
  // stage 4
  logic signed [CW-1:0] s4_ax, s4_ay;
  logic signed [DW-1:0] s4_d1x, s4_d1y;
  logic signed [SW-1:0] s4_sn, s4_tn;
  logic [PW-1:0]        s4_dmag;
  logic                 s4_dz, s4_rej;
  // stage 5
  logic signed [CW-1:0] s5_ax, s5_ay;
  logic [PW-1:0]        s5_dmag, s5_tm;
  logic [AW-1:0]        s5_axm, s5_aym;
  logic                 s5_sx, s5_sy, s5_found, s5_par;
  // stage 6
  logic signed [CW-1:0] s6_ax, s6_ay;
  logic [PW-1:0]        s6_dmag;
  logic [LW+AW-1:0]     s6_pxl, s6_pyl;
  logic [HW+AW-1:0]     s6_pxh, s6_pyh;
  logic                 s6_sx, s6_sy, s6_found, s6_par;
  // divider chain, entry 0 is stage 7
  div_stage_t           dv [QW+1];
  div_stage_t           dn [QW];
  logic [NW-1:0]        dsh [QW];
  logic [QW-1:0]        gx, gy;
  // rounding stage
  logic signed [IW-1:0] r1_ix, r1_iy;
  logic                 r1_sx, r1_sy, r1_gex, r1_gtx, r1_gey, r1_gty;
  logic                 r1_found, r1_par;

  // ready chain: a stage moves when empty or when its successor moves
  assign rdy[NS] = !result_stall;
  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = !st_v[i] || rdy[i+1];
  end
  assign item_stall   = !rdy[0];
  assign result_valid = st_v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= '0;
    end else begin
      if (rdy[0]) begin
        st_v[0] <= item_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          st_v[i] <= st_v[i-1];
        end
      end
    end
  end

  // stage 1 combinational
  logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e, ex_e, ey_e;
  logic signed [DW-1:0] lo1, hi1, lo2, hi2;
  assign ax_e = DW'(item.first_start_x);
  assign ay_e = DW'(item.first_start_y);
  assign bx_e = DW'(item.first_end_x);
  assign by_e = DW'(item.first_end_y);
  assign cx_e = DW'(item.second_start_x);
  assign cy_e = DW'(item.second_start_y);
  assign ex_e = DW'(item.second_end_x);
  assign ey_e = DW'(item.second_end_y);
  assign lo1  = (ay_e < by_e) ? ay_e : by_e;
  assign hi1  = (ay_e < by_e) ? by_e : ay_e;
  assign lo2  = (cy_e < ey_e) ? cy_e : ey_e;
  assign hi2  = (cy_e < ey_e) ? ey_e : cy_e;

  // stage 4 combinational: sign of d
  logic                 d_neg;
  logic signed [SW-1:0] d_abs;
  assign d_neg = s3_d[SW-1];
  assign d_abs = d_neg ? -s3_d : s3_d;

  // stage 5 combinational: endpoint rule
  logic signed [SW-1:0] dm;
  logic sn_pos, tn_pos, s_in, t_in, s_end, t_end, hit;
  assign dm     = $signed({1'b0, s4_dmag});
  assign sn_pos = !s4_sn[SW-1] && (s4_sn != '0);
  assign tn_pos = !s4_tn[SW-1] && (s4_tn != '0);
  assign s_in   = sn_pos && (s4_sn < dm);
  assign t_in   = tn_pos && (s4_tn < dm);
  assign s_end  = (s4_sn == '0) || (s4_sn == dm);
  assign t_end  = (s4_tn == '0) || (s4_tn == dm);
  assign hit    = (s_end && t_in) || (t_end && s_in) || (s_in && t_in);

  // divider compares
  for (genvar k = 0; k < QW; k++) begin : g_div
    assign dsh[k] = NW'(dv[k].dmag) << (QW - 1 - k);
    assign gx[k]  = dv[k].rx >= dsh[k];
    assign gy[k]  = dv[k].ry >= dsh[k];
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      dn[k]              = dv[k];
      dn[k].rx           = gx[k] ? dv[k].rx - dsh[k] : dv[k].rx;
      dn[k].ry           = gy[k] ? dv[k].ry - dsh[k] : dv[k].ry;
      dn[k].qx[QW-1-k]   = gx[k];
      dn[k].qy[QW-1-k]   = gy[k];
    end
  end

  // rounding stage combinational
  logic signed [IW-1:0] qxe, qye;
  assign qxe = $signed({1'b0, dv[QW].qx});
  assign qye = $signed({1'b0, dv[QW].qy});

  // output stage combinational: round the whole sum half away from zero
  logic                 ixneg, ixnp, iyneg, iynp, adj_x, adj_y;
  logic signed [IW-1:0] xr, yr;
  assign ixneg = r1_ix[IW-1];
  assign iyneg = r1_iy[IW-1];
  assign ixnp  = ixneg || (r1_ix == '0);
  assign iynp  = iyneg || (r1_iy == '0);
  assign adj_x = r1_sx ? (ixnp ? r1_gex : r1_gtx) : (ixneg ? r1_gtx : r1_gex);
  assign adj_y = r1_sy ? (iynp ? r1_gey : r1_gty) : (iyneg ? r1_gty : r1_gey);
  assign xr = r1_sx ? r1_ix - $signed({{(IW-1){1'b0}}, adj_x})
                    : r1_ix + $signed({{(IW-1){1'b0}}, adj_x});
  assign yr = r1_sy ? r1_iy - $signed({{(IW-1){1'b0}}, adj_y})
                    : r1_iy + $signed({{(IW-1){1'b0}}, adj_y});

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_ax  <= item.first_start_x;
      s1_ay  <= item.first_start_y;
      s1_d1x <= bx_e - ax_e;
      s1_d1y <= by_e - ay_e;
      s1_d2x <= ex_e - cx_e;
      s1_d2y <= ey_e - cy_e;
      s1_ox  <= ax_e - cx_e;
      s1_oy  <= ay_e - cy_e;
      s1_rej <= (hi1 < lo2) || (lo1 > hi2);
    end
    if (rdy[1]) begin
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
      s2_d1x <= s1_d1x;
      s2_d1y <= s1_d1y;
      s2_rej <= s1_rej;
      s2_pd0 <= PW'(s1_d1x) * PW'(s1_d2y);
      s2_pd1 <= PW'(s1_d2x) * PW'(s1_d1y);
      s2_ps0 <= PW'(s1_d1x) * PW'(s1_oy);
      s2_ps1 <= PW'(s1_d1y) * PW'(s1_ox);
      s2_pt0 <= PW'(s1_d2x) * PW'(s1_oy);
      s2_pt1 <= PW'(s1_d2y) * PW'(s1_ox);
    end
    if (rdy[2]) begin
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_d1x <= s2_d1x;
      s3_d1y <= s2_d1y;
      s3_rej <= s2_rej;
      s3_d   <= SW'(s2_pd0) - SW'(s2_pd1);
      s3_sn  <= SW'(s2_ps0) - SW'(s2_ps1);
      s3_tn  <= SW'(s2_pt0) - SW'(s2_pt1);
    end
    if (rdy[3]) begin
      s4_ax   <= s3_ax;
      s4_ay   <= s3_ay;
      s4_d1x  <= s3_d1x;
      s4_d1y  <= s3_d1y;
      s4_rej  <= s3_rej;
      s4_dz   <= (s3_d == '0);
      s4_dmag <= d_abs[PW-1:0];
      s4_sn   <= d_neg ? -s3_sn : s3_sn;
      s4_tn   <= d_neg ? -s3_tn : s3_tn;
    end
    if (rdy[4]) begin
      s5_ax    <= s4_ax;
      s5_ay    <= s4_ay;
      s5_dmag  <= s4_dmag;
      s5_tm    <= s4_tn[PW-1:0];
      s5_sx    <= s4_d1x[DW-1];
      s5_sy    <= s4_d1y[DW-1];
      s5_axm   <= s4_d1x[DW-1] ? AW'(-s4_d1x) : AW'(s4_d1x);
      s5_aym   <= s4_d1y[DW-1] ? AW'(-s4_d1y) : AW'(s4_d1y);
      s5_found <= !s4_rej && !s4_dz && hit;
      s5_par   <= !s4_rej && s4_dz;
    end
    if (rdy[5]) begin
      s6_ax    <= s5_ax;
      s6_ay    <= s5_ay;
      s6_dmag  <= s5_dmag;
      s6_sx    <= s5_sx;
      s6_sy    <= s5_sy;
      s6_found <= s5_found;
      s6_par   <= s5_par;
      s6_pxl   <= (LW+AW)'(s5_tm[LW-1:0]) * (LW+AW)'(s5_axm);
      s6_pxh   <= (HW+AW)'(s5_tm[PW-1:LW]) * (HW+AW)'(s5_axm);
      s6_pyl   <= (LW+AW)'(s5_tm[LW-1:0]) * (LW+AW)'(s5_aym);
      s6_pyh   <= (HW+AW)'(s5_tm[PW-1:LW]) * (HW+AW)'(s5_aym);
    end
    if (rdy[6]) begin
      dv[0].rx    <= NW'(s6_pxl) + (NW'(s6_pxh) << LW);
      dv[0].ry    <= NW'(s6_pyl) + (NW'(s6_pyh) << LW);
      dv[0].qx    <= '0;
      dv[0].qy    <= '0;
      dv[0].dmag  <= s6_dmag;
      dv[0].ax    <= s6_ax;
      dv[0].ay    <= s6_ay;
      dv[0].sx    <= s6_sx;
      dv[0].sy    <= s6_sy;
      dv[0].found <= s6_found;
      dv[0].par   <= s6_par;
    end
    for (int k = 0; k < QW; k++) begin
      if (rdy[DS+k]) begin
        dv[k+1] <= dn[k];
      end
    end
    if (rdy[DS+QW]) begin
      r1_ix    <= IW'(dv[QW].ax) + (dv[QW].sx ? -qxe : qxe);
      r1_iy    <= IW'(dv[QW].ay) + (dv[QW].sy ? -qye : qye);
      r1_sx    <= dv[QW].sx;
      r1_sy    <= dv[QW].sy;
      r1_gex   <= {dv[QW].rx[PW-1:0], 1'b0} >= {1'b0, dv[QW].dmag};
      r1_gtx   <= {dv[QW].rx[PW-1:0], 1'b0} >  {1'b0, dv[QW].dmag};
      r1_gey   <= {dv[QW].ry[PW-1:0], 1'b0} >= {1'b0, dv[QW].dmag};
      r1_gty   <= {dv[QW].ry[PW-1:0], 1'b0} >  {1'b0, dv[QW].dmag};
      r1_found <= dv[QW].found;
      r1_par   <= dv[QW].par;
    end
    if (rdy[NS-1]) begin
      result.found         <= r1_found;
      result.parallel_flag <= r1_par;
      result.cross_x       <= r1_found ? xr[CW-1:0] : '1;
      result.cross_y       <= r1_found ? yr[CW-1:0] : '1;
    end
  end

endmodule

// File: design/sip_checker.sv
// ----------------------------------------------------------------------------
// sip_checker: port-level checks for the segment intersection point core
// Watches both channels and the result payload over time.
// ----------------------------------------------------------------------------
module sip_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input sip_pkg::crossing_t result
);

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // an empty or draining output never backs up the input
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || !result_stall) |-> !item_stall)
    else $error("input stalled while output moves");

  // a miss carries all-ones coordinates
  a_miss: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      (result.cross_x == '1) && (result.cross_y == '1))
    else $error("miss with coordinates");

  // parallel pairs never report a hit
  a_par: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.found && result.parallel_flag))
    else $error("hit flagged parallel");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind segment_intersection_point_core sip_checker u_sip_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
